### rtl/core/sdspi_pkg.sv
package sdspi_pkg;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_CLK   = 4'd1,
      PH_FRAME = 4'd2,
      PH_POLL  = 4'd3,
      PH_TRAIL = 4'd4,
      PH_REL   = 4'd5,
      PH_TOKEN = 4'd6,
      PH_RDATA = 4'd7,
      PH_RCRC  = 4'd8,
      PH_WGAP  = 4'd9,
      PH_WDATA = 4'd10,
      PH_WCRC  = 4'd11,
      PH_WRESP = 4'd12,
      PH_BUSY  = 4'd13,
      PH_FIN   = 4'd14
   } phase_type;

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_BYTE  = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_IDLE_TO   = 3'd1;
   localparam logic [2:0] ST_OPCOND_TO = 3'd2;
   localparam logic [2:0] ST_CMD_REJ   = 3'd3;
   localparam logic [2:0] ST_TOKEN_TO  = 3'd4;
   localparam logic [2:0] ST_DATA_REJ  = 3'd5;

   localparam logic [1:0] CARD_UNKNOWN = 2'd0;
   localparam logic [1:0] CARD_SC      = 2'd1;
   localparam logic [1:0] CARD_HC      = 2'd2;

   localparam logic [5:0] CMD0  = 6'd0;
   localparam logic [5:0] CMD8  = 6'd8;
   localparam logic [5:0] CMD16 = 6'd16;
   localparam logic [5:0] CMD17 = 6'd17;
   localparam logic [5:0] CMD24 = 6'd24;
   localparam logic [5:0] CMD41 = 6'd41;
   localparam logic [5:0] CMD55 = 6'd55;

   localparam logic [2:0] CSR_INIT_CLK  = 3'd0;
   localparam logic [2:0] CSR_IDLE_RTY  = 3'd1;
   localparam logic [2:0] CSR_OPC_RTY   = 3'd2;
   localparam logic [2:0] CSR_TOKEN_LIM = 3'd3;
   localparam logic [2:0] CSR_POLL_LIM  = 3'd4;

   localparam logic [7:0]  FILL_BYTE    = 8'hFF;
   localparam logic [7:0]  START_TOKEN  = 8'hFE;
   localparam logic [9:0]  SECTOR_BYTES = 10'd512;
   localparam logic [31:0] ARG_CHECK    = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
   localparam logic [31:0] ARG_BLKLEN   = 32'd512;

   // One result word.
   typedef struct packed {
      logic [1:0] card_kind;
      logic [2:0] status;
      logic       done_res;
      logic       wr_request;
      logic [7:0] rd_byte;
      logic       rd_valid;
      logic       clock_fast;
      logic       select_active;
      logic [7:0] tx_byte;
      logic       tx_valid;
   } result_type;

   typedef struct packed {
      logic [7:0]  init_clock_bytes;
      logic [15:0] go_idle_retries;
      logic [15:0] op_cond_retries;
      logic [15:0] token_wait_limit;
      logic [7:0]  response_poll_limit;
   } cfg_type;

endpackage

### rtl/core/sdspi_fsm.sv
module sdspi_fsm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [1:0]            opcode,
   input  logic [31:0]           sector,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            wr_byte,
   input  sdspi_pkg::cfg_type    cfg,
   output sdspi_pkg::result_type result
);

   sdspi_pkg::phase_type phase_ff, phase_in;
   logic [9:0]  byte_count_ff, byte_count_in;
   logic [15:0] retry_count_ff, retry_count_in;
   logic [7:0]  poll_count_ff, poll_count_in;
   logic [2:0]  frame_index_ff, frame_index_in;
   logic [5:0]  command_index_ff, command_index_in;
   logic [31:0] command_argument_ff, command_argument_in;
   logic [7:0]  last_response_ff, last_response_in;
   logic [1:0]  card_type_ff, card_type_in;
   logic        fast_clock_ff, fast_clock_in;
   logic        v2_card_ff, v2_card_in;
   logic        echo_ok_ff, echo_ok_in;
   logic [2:0]  pend_status_ff, pend_status_in;

   logic [15:0] retry_inc;

   function automatic logic [7:0] frame_byte(input logic [2:0] i, input logic [5:0] idx,
                                             input logic [31:0] arg);
      logic [7:0] b;
      case (i)
         3'd0: b = {2'b01, idx};
         3'd1: b = arg[31:24];
         3'd2: b = arg[23:16];
         3'd3: b = arg[15:8];
         3'd4: b = arg[7:0];
         default: begin
            if (idx == sdspi_pkg::CMD0) b = 8'h95;
            else if (idx == sdspi_pkg::CMD8) b = 8'h87;
            else b = 8'h01;
         end
      endcase
      return b;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= sdspi_pkg::PH_IDLE;
         byte_count_ff       <= '0;
         retry_count_ff      <= '0;
         poll_count_ff       <= '0;
         frame_index_ff      <= '0;
         command_index_ff    <= '0;
         command_argument_ff <= '0;
         last_response_ff    <= 8'hFF;
         card_type_ff        <= sdspi_pkg::CARD_UNKNOWN;
         fast_clock_ff       <= 1'b0;
         v2_card_ff          <= 1'b0;
         echo_ok_ff          <= 1'b0;
         pend_status_ff      <= sdspi_pkg::ST_OK;
      end else if (step) begin
         phase_ff            <= phase_in;
         byte_count_ff       <= byte_count_in;
         retry_count_ff      <= retry_count_in;
         poll_count_ff       <= poll_count_in;
         frame_index_ff      <= frame_index_in;
         command_index_ff    <= command_index_in;
         command_argument_ff <= command_argument_in;
         last_response_ff    <= last_response_in;
         card_type_ff        <= card_type_in;
         fast_clock_ff       <= fast_clock_in;
         v2_card_ff          <= v2_card_in;
         echo_ok_ff          <= echo_ok_in;
         pend_status_ff      <= pend_status_in;
      end
   end

   assign retry_inc = retry_count_ff + 16'd1;

   always_comb begin
      logic        do_start;
      logic [5:0]  s_idx;
      logic [31:0] s_arg;
      logic        do_finish;
      logic [2:0]  f_st;
      logic        do_release;
      logic [2:0]  r_st;
      logic        do_send;
      logic [7:0]  s_byte;
      logic        s_sel;

      do_start   = 1'b0;
      s_idx      = '0;
      s_arg      = '0;
      do_finish  = 1'b0;
      f_st       = sdspi_pkg::ST_OK;
      do_release = 1'b0;
      r_st       = sdspi_pkg::ST_OK;
      do_send    = 1'b0;
      s_byte     = sdspi_pkg::FILL_BYTE;
      s_sel      = 1'b1;

      phase_in            = phase_ff;
      byte_count_in       = byte_count_ff;
      retry_count_in      = retry_count_ff;
      poll_count_in       = poll_count_ff;
      frame_index_in      = frame_index_ff;
      command_index_in    = command_index_ff;
      command_argument_in = command_argument_ff;
      last_response_in    = last_response_ff;
      card_type_in        = card_type_ff;
      fast_clock_in       = fast_clock_ff;
      v2_card_in          = v2_card_ff;
      echo_ok_in          = echo_ok_ff;
      pend_status_in      = pend_status_ff;
      result              = '0;

      if (opcode == sdspi_pkg::OP_BYTE) begin
         case (phase_ff)
            sdspi_pkg::PH_CLK: begin
               if (byte_count_ff < {2'b00, cfg.init_clock_bytes}) begin
                  byte_count_in = byte_count_ff + 10'd1;
                  do_send = 1'b1;
                  s_sel   = 1'b0;
               end else begin
                  retry_count_in = '0;
                  do_start = 1'b1;
                  s_idx    = sdspi_pkg::CMD0;
               end
            end
            sdspi_pkg::PH_FRAME: begin
               if (frame_index_ff < 3'd6) begin
                  do_send = 1'b1;
                  s_byte  = frame_byte(frame_index_ff, command_index_ff, command_argument_ff);
                  frame_index_in = frame_index_ff + 3'd1;
               end else begin
                  phase_in      = sdspi_pkg::PH_POLL;
                  poll_count_in = 8'd1;
                  do_send       = 1'b1;
               end
            end
            sdspi_pkg::PH_POLL: begin
               last_response_in = rx_byte;
               if (!rx_byte[7] || poll_count_ff >= cfg.response_poll_limit) begin
                  if (command_index_ff == sdspi_pkg::CMD8 && rx_byte == 8'h01) begin
                     phase_in      = sdspi_pkg::PH_TRAIL;
                     byte_count_in = '0;
                     do_send       = 1'b1;
                  end else begin
                     phase_in = sdspi_pkg::PH_REL;
                     do_send  = 1'b1;
                     s_sel    = 1'b0;
                  end
               end else begin
                  poll_count_in = poll_count_ff + 8'd1;
                  do_send       = 1'b1;
               end
            end
            sdspi_pkg::PH_TRAIL: begin
               byte_count_in = byte_count_ff + 10'd1;
               if (byte_count_in == 10'd3) echo_ok_in = (rx_byte == 8'h01);
               do_send = 1'b1;
               if (byte_count_in >= 10'd4) begin
                  echo_ok_in = echo_ok_ff && (rx_byte == 8'hAA);
                  phase_in   = sdspi_pkg::PH_REL;
                  s_sel      = 1'b0;
               end
            end
            sdspi_pkg::PH_REL: begin
               case (command_index_ff)
                  sdspi_pkg::CMD0: begin
                     if (last_response_ff == 8'h01) begin
                        echo_ok_in = 1'b0;
                        do_start = 1'b1;
                        s_idx    = sdspi_pkg::CMD8;
                        s_arg    = sdspi_pkg::ARG_CHECK;
                     end else begin
                        retry_count_in = retry_inc;
                        if (retry_inc >= cfg.go_idle_retries) begin
                           do_finish = 1'b1;
                           f_st      = sdspi_pkg::ST_IDLE_TO;
                        end else begin
                           do_start = 1'b1;
                           s_idx    = sdspi_pkg::CMD0;
                        end
                     end
                  end
                  sdspi_pkg::CMD8: begin
                     if (last_response_ff == 8'h01 && !echo_ok_ff) begin
                        do_start = 1'b1;
                        s_idx    = sdspi_pkg::CMD16;
                        s_arg    = sdspi_pkg::ARG_BLKLEN;
                     end else begin
                        v2_card_in     = (last_response_ff == 8'h01);
                        retry_count_in = '0;
                        do_start = 1'b1;
                        s_idx    = sdspi_pkg::CMD55;
                     end
                  end
                  sdspi_pkg::CMD55: begin
                     do_start = 1'b1;
                     s_idx    = sdspi_pkg::CMD41;
                     s_arg    = v2_card_ff ? sdspi_pkg::ARG_HCS : 32'd0;
                  end
                  sdspi_pkg::CMD41: begin
                     if (last_response_ff == 8'h00) begin
                        card_type_in = v2_card_ff ? sdspi_pkg::CARD_HC : sdspi_pkg::CARD_SC;
                        do_start = 1'b1;
                        s_idx    = sdspi_pkg::CMD16;
                        s_arg    = sdspi_pkg::ARG_BLKLEN;
                     end else begin
                        retry_count_in = retry_inc;
                        if (retry_inc >= cfg.op_cond_retries) begin
                           do_finish = 1'b1;
                           f_st      = sdspi_pkg::ST_OPCOND_TO;
                        end else begin
                           do_start = 1'b1;
                           s_idx    = sdspi_pkg::CMD55;
                        end
                     end
                  end
                  sdspi_pkg::CMD16: begin
                     do_finish = 1'b1;
                     if (last_response_ff == 8'h00) begin
                        fast_clock_in = 1'b1;
                        f_st = sdspi_pkg::ST_OK;
                     end else begin
                        f_st = sdspi_pkg::ST_CMD_REJ;
                     end
                  end
                  sdspi_pkg::CMD17: begin
                     if (last_response_ff != 8'h00) begin
                        do_finish = 1'b1;
                        f_st      = sdspi_pkg::ST_CMD_REJ;
                     end else begin
                        phase_in       = sdspi_pkg::PH_TOKEN;
                        retry_count_in = 16'd1;
                        do_send        = 1'b1;
                     end
                  end
                  sdspi_pkg::CMD24: begin
                     if (last_response_ff != 8'h00) begin
                        do_finish = 1'b1;
                        f_st      = sdspi_pkg::ST_CMD_REJ;
                     end else begin
                        phase_in = sdspi_pkg::PH_WGAP;
                        do_send  = 1'b1;
                     end
                  end
                  default: begin
                     do_finish = 1'b1;
                     f_st      = sdspi_pkg::ST_OK;
                  end
               endcase
            end
            sdspi_pkg::PH_TOKEN: begin
               if (rx_byte == sdspi_pkg::START_TOKEN) begin
                  phase_in      = sdspi_pkg::PH_RDATA;
                  byte_count_in = '0;
                  do_send       = 1'b1;
               end else if (retry_count_ff >= cfg.token_wait_limit) begin
                  do_release = 1'b1;
                  r_st       = sdspi_pkg::ST_TOKEN_TO;
               end else begin
                  retry_count_in = retry_inc;
                  do_send        = 1'b1;
               end
            end
            sdspi_pkg::PH_RDATA: begin
               result.rd_valid = 1'b1;
               result.rd_byte  = rx_byte;
               byte_count_in   = byte_count_ff + 10'd1;
               if (byte_count_ff + 10'd1 == sdspi_pkg::SECTOR_BYTES
                   || byte_count_ff >= sdspi_pkg::SECTOR_BYTES) begin
                  phase_in      = sdspi_pkg::PH_RCRC;
                  byte_count_in = 10'd1;
               end
               do_send = 1'b1;
            end
            sdspi_pkg::PH_RCRC: begin
               if (byte_count_ff < 10'd2) begin
                  byte_count_in = byte_count_ff + 10'd1;
                  do_send       = 1'b1;
               end else begin
                  do_release = 1'b1;
                  r_st       = sdspi_pkg::ST_OK;
               end
            end
            sdspi_pkg::PH_WGAP: begin
               phase_in          = sdspi_pkg::PH_WDATA;
               byte_count_in     = '0;
               result.wr_request = 1'b1;
               do_send           = 1'b1;
               s_byte            = sdspi_pkg::START_TOKEN;
            end
            sdspi_pkg::PH_WDATA: begin
               do_send = 1'b1;
               s_byte  = wr_byte;
               byte_count_in = byte_count_ff + 10'd1;
               if (byte_count_ff + 10'd1 != sdspi_pkg::SECTOR_BYTES
                   && byte_count_ff < sdspi_pkg::SECTOR_BYTES) begin
                  result.wr_request = 1'b1;
               end else begin
                  phase_in      = sdspi_pkg::PH_WCRC;
                  byte_count_in = '0;
               end
            end
            sdspi_pkg::PH_WCRC: begin
               byte_count_in = byte_count_ff + 10'd1;
               if (byte_count_in >= 10'd3) phase_in = sdspi_pkg::PH_WRESP;
               do_send = 1'b1;
            end
            sdspi_pkg::PH_WRESP: begin
               if (rx_byte[4:0] != 5'h05) begin
                  do_release = 1'b1;
                  r_st       = sdspi_pkg::ST_DATA_REJ;
               end else begin
                  phase_in = sdspi_pkg::PH_BUSY;
                  do_send  = 1'b1;
               end
            end
            sdspi_pkg::PH_BUSY: begin
               if (rx_byte == 8'h00) begin
                  do_send = 1'b1;
               end else begin
                  do_release = 1'b1;
                  r_st       = sdspi_pkg::ST_OK;
               end
            end
            sdspi_pkg::PH_FIN: begin
               do_finish = 1'b1;
               f_st      = pend_status_ff;
            end
            default: phase_in = sdspi_pkg::PH_IDLE;
         endcase
      end else if (phase_ff == sdspi_pkg::PH_IDLE) begin
         if (opcode == sdspi_pkg::OP_INIT) begin
            fast_clock_in = 1'b0;
            card_type_in  = sdspi_pkg::CARD_UNKNOWN;
            v2_card_in    = 1'b0;
            phase_in      = sdspi_pkg::PH_CLK;
            byte_count_in = 10'd1;
            do_send       = 1'b1;
            s_sel         = 1'b0;
         end else begin
            do_start = 1'b1;
            s_idx    = (opcode == sdspi_pkg::OP_READ) ? sdspi_pkg::CMD17 : sdspi_pkg::CMD24;
            s_arg    = (card_type_ff == sdspi_pkg::CARD_HC) ? sector : {sector[22:0], 9'd0};
         end
      end

      if (do_start) begin
         command_index_in    = s_idx;
         command_argument_in = s_arg;
         frame_index_in      = 3'd1;
         phase_in            = sdspi_pkg::PH_FRAME;
         do_send             = 1'b1;
         s_byte              = {2'b01, s_idx};
         s_sel               = 1'b1;
      end
      if (do_release) begin
         pend_status_in = r_st;
         phase_in       = sdspi_pkg::PH_FIN;
         do_send        = 1'b1;
         s_byte         = sdspi_pkg::FILL_BYTE;
         s_sel          = 1'b0;
      end
      if (do_finish) begin
         result.done_res = 1'b1;
         result.status   = f_st;
         phase_in        = sdspi_pkg::PH_IDLE;
      end
      if (do_send) begin
         result.tx_valid      = 1'b1;
         result.tx_byte       = s_byte;
         result.select_active = s_sel;
      end
      result.clock_fast = fast_clock_in;
      result.card_kind  = card_type_in;
   end

   property p_done_idle;
      @(posedge clock) disable iff (reset)
         step && result.done_res |=> phase_ff == sdspi_pkg::PH_IDLE;
   endproperty
   a_done_idle: assert property (p_done_idle) else $error("done without return to idle");

   property p_done_no_tx;
      @(posedge clock) disable iff (reset) result.done_res |-> !result.tx_valid;
   endproperty
   a_done_no_tx: assert property (p_done_no_tx) else $error("done with exchange");

   property p_fast_card;
      @(posedge clock) disable iff (reset)
         fast_clock_ff |-> !(phase_ff == sdspi_pkg::PH_CLK);
   endproperty
   a_fast_card: assert property (p_fast_card) else $error("fast clock during init clocks");

endmodule

### rtl/core/sd_card_spi_host_controller.sv
// A word accepted on req_ gives its result word on rsp_ in the next cycle.
// One word per cycle while the result register is free or being drained; the
// phase machine decides each byte combinationally before the result register.
// Reset: synchronous, active high; the phase machine returns to idle, the card kind
// to unknown and the configuration registers to their defaults.
module sd_card_spi_host_controller (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: opcode[1:0], sector[33:2], rx_byte[41:34], wr_byte[49:42], zeros.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   // rsp_tdata: tx_valid[0], tx_byte[8:1], select_active[9], clock_fast[10],
   // rd_valid[11], rd_byte[19:12], wr_request[20], done_res[21], status[24:22],
   // card_kind[26:25], zeros.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   sdspi_pkg::cfg_type    cfg_ff;
   sdspi_pkg::result_type result;
   logic                  step;
   logic                  rsp_valid_ff;
   logic [26:0]           rsp_data_ff;

   // The result register is the only buffer; a new word enters when it is free or
   // is being taken in this same cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_clock_bytes    <= 8'd10;
         cfg_ff.go_idle_retries     <= 16'd200;
         cfg_ff.op_cond_retries     <= 16'd1000;
         cfg_ff.token_wait_limit    <= 16'd500;
         cfg_ff.response_poll_limit <= 8'd8;
      end else if (csr_valid) begin
         case (csr_index)
            sdspi_pkg::CSR_INIT_CLK:  cfg_ff.init_clock_bytes    <= csr_data[7:0];
            sdspi_pkg::CSR_IDLE_RTY:  cfg_ff.go_idle_retries     <= csr_data;
            sdspi_pkg::CSR_OPC_RTY:   cfg_ff.op_cond_retries     <= csr_data;
            sdspi_pkg::CSR_TOKEN_LIM: cfg_ff.token_wait_limit    <= csr_data;
            sdspi_pkg::CSR_POLL_LIM:  cfg_ff.response_poll_limit <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   sdspi_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .opcode  (req_tdata[1:0]),
      .sector  (req_tdata[33:2]),
      .rx_byte (req_tdata[41:34]),
      .wr_byte (req_tdata[49:42]),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule

### verif/sdspi_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register channels of the SD card SPI host
// controller, predicts each result word and compares it with what comes out.
module sdspi_checker
   import sdspi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          err_count,
   output int          pending,
   output int          checked,
   output phase_type   pv_phase,
   output logic [5:0]  pv_cmd,
   output logic [9:0]  pv_count
);

   typedef struct packed {
      phase_type   ph;
      logic [9:0]  bytes;
      logic [15:0] retries;
      logic [7:0]  polls;
      logic [2:0]  frame_pos;
      logic [5:0]  cmd;
      logic [31:0] arg;
      logic [7:0]  last_r1;
      logic [1:0]  kind;
      logic        fast;
      logic        v2;
      logic        echo_ok;
      logic [2:0]  pend;
      cfg_type     cfg;
   } host_state_t;

   host_state_t host_now, host_next, pv_state;
   result_type  due_q[$];
   result_type  got, want, step_out, pv_out;

   function automatic host_state_t reset_state();
      host_state_t s;
      s = '0;
      s.ph = PH_IDLE;
      s.last_r1 = 8'hFF;
      s.cfg.init_clock_bytes = 8'd10;
      s.cfg.go_idle_retries = 16'd200;
      s.cfg.op_cond_retries = 16'd1000;
      s.cfg.token_wait_limit = 16'd500;
      s.cfg.response_poll_limit = 8'd8;
      return s;
   endfunction

   function automatic void emit(inout result_type r, input logic [7:0] b, input logic sel);
      r.tx_valid = 1'b1;
      r.tx_byte = b;
      r.select_active = sel;
   endfunction

   function automatic void finish_req(inout host_state_t s, inout result_type r,
                                      input logic [2:0] st);
      r.done_res = 1'b1;
      r.status = st;
      s.ph = PH_IDLE;
   endfunction

   // The card gets one release byte before the request reports its status.
   function automatic void release_then(inout host_state_t s, inout result_type r,
                                        input logic [2:0] st);
      s.pend = st;
      emit(r, FILL_BYTE, 1'b0);
      s.ph = PH_FIN;
   endfunction

   function automatic logic [7:0] frame_byte(host_state_t s, int pos);
      if (pos == 0) return {2'b01, s.cmd};
      if (pos <= 4) return 8'(s.arg >> (32 - 8 * pos));
      if (s.cmd == CMD0) return 8'h95;
      if (s.cmd == CMD8) return 8'h87;
      return 8'h01;
   endfunction

   function automatic void start_cmd(inout host_state_t s, inout result_type r,
                                     input logic [5:0] idx, input logic [31:0] arg);
      s.cmd = idx;
      s.arg = arg;
      s.frame_pos = 3'd1;
      s.ph = PH_FRAME;
      emit(r, frame_byte(s, 0), 1'b1);
   endfunction

   // Decides what follows a finished command from its R1 response.
   function automatic void next_command(inout host_state_t s, inout result_type r);
      case (s.cmd)
         CMD0: begin
            if (s.last_r1 == 8'h01) begin
               s.echo_ok = 1'b0;
               start_cmd(s, r, CMD8, ARG_CHECK);
            end else begin
               s.retries++;
               if (s.retries >= s.cfg.go_idle_retries) finish_req(s, r, ST_IDLE_TO);
               else start_cmd(s, r, CMD0, 32'd0);
            end
         end
         CMD8: begin
            if (s.last_r1 == 8'h01 && !s.echo_ok) begin
               start_cmd(s, r, CMD16, ARG_BLKLEN);
            end else begin
               s.v2 = (s.last_r1 == 8'h01);
               s.retries = '0;
               start_cmd(s, r, CMD55, 32'd0);
            end
         end
         CMD55: start_cmd(s, r, CMD41, s.v2 ? ARG_HCS : 32'd0);
         CMD41: begin
            if (s.last_r1 == 8'h00) begin
               s.kind = s.v2 ? CARD_HC : CARD_SC;
               start_cmd(s, r, CMD16, ARG_BLKLEN);
            end else begin
               s.retries++;
               if (s.retries >= s.cfg.op_cond_retries) finish_req(s, r, ST_OPCOND_TO);
               else start_cmd(s, r, CMD55, 32'd0);
            end
         end
         CMD16: begin
            if (s.last_r1 == 8'h00) begin
               s.fast = 1'b1;
               finish_req(s, r, ST_OK);
            end else begin
               finish_req(s, r, ST_CMD_REJ);
            end
         end
         CMD17: begin
            if (s.last_r1 != 8'h00) begin
               finish_req(s, r, ST_CMD_REJ);
            end else begin
               s.ph = PH_TOKEN;
               s.retries = 16'd1;
               emit(r, FILL_BYTE, 1'b1);
            end
         end
         CMD24: begin
            if (s.last_r1 != 8'h00) begin
               finish_req(s, r, ST_CMD_REJ);
            end else begin
               s.ph = PH_WGAP;
               emit(r, FILL_BYTE, 1'b1);
            end
         end
         default: finish_req(s, r, ST_OK);
      endcase
   endfunction

   function automatic void on_exchange(inout host_state_t s, inout result_type r,
                                       input logic [7:0] rx, input logic [7:0] wb);
      case (s.ph)
         PH_CLK: begin
            if (s.bytes < s.cfg.init_clock_bytes) begin
               s.bytes++;
               emit(r, FILL_BYTE, 1'b0);
            end else begin
               s.retries = '0;
               start_cmd(s, r, CMD0, 32'd0);
            end
         end
         PH_FRAME: begin
            if (s.frame_pos < 3'd6) begin
               emit(r, frame_byte(s, s.frame_pos), 1'b1);
               s.frame_pos++;
            end else begin
               s.ph = PH_POLL;
               s.polls = 8'd1;
               emit(r, FILL_BYTE, 1'b1);
            end
         end
         PH_POLL: begin
            s.last_r1 = rx;
            if (!rx[7] || s.polls >= s.cfg.response_poll_limit) begin
               if (s.cmd == CMD8 && rx == 8'h01) begin
                  s.ph = PH_TRAIL;
                  s.bytes = '0;
                  emit(r, FILL_BYTE, 1'b1);
               end else begin
                  s.ph = PH_REL;
                  emit(r, FILL_BYTE, 1'b0);
               end
            end else begin
               s.polls++;
               emit(r, FILL_BYTE, 1'b1);
            end
         end
         PH_TRAIL: begin
            s.bytes++;
            if (s.bytes == 10'd3) s.echo_ok = (rx == 8'h01);
            if (s.bytes >= 10'd4) begin
               s.echo_ok = s.echo_ok && (rx == 8'hAA);
               s.ph = PH_REL;
               emit(r, FILL_BYTE, 1'b0);
            end else begin
               emit(r, FILL_BYTE, 1'b1);
            end
         end
         PH_REL: next_command(s, r);
         PH_TOKEN: begin
            if (rx == START_TOKEN) begin
               s.ph = PH_RDATA;
               s.bytes = '0;
               emit(r, FILL_BYTE, 1'b1);
            end else if (s.retries >= s.cfg.token_wait_limit) begin
               release_then(s, r, ST_TOKEN_TO);
            end else begin
               s.retries++;
               emit(r, FILL_BYTE, 1'b1);
            end
         end
         PH_RDATA: begin
            r.rd_valid = 1'b1;
            r.rd_byte = rx;
            s.bytes++;
            if (s.bytes >= SECTOR_BYTES) begin
               s.ph = PH_RCRC;
               s.bytes = 10'd1;
            end
            emit(r, FILL_BYTE, 1'b1);
         end
         PH_RCRC: begin
            if (s.bytes < 10'd2) begin
               s.bytes++;
               emit(r, FILL_BYTE, 1'b1);
            end else begin
               release_then(s, r, ST_OK);
            end
         end
         PH_WGAP: begin
            s.ph = PH_WDATA;
            s.bytes = '0;
            r.wr_request = 1'b1;
            emit(r, START_TOKEN, 1'b1);
         end
         PH_WDATA: begin
            emit(r, wb, 1'b1);
            s.bytes++;
            if (s.bytes < SECTOR_BYTES) begin
               r.wr_request = 1'b1;
            end else begin
               s.ph = PH_WCRC;
               s.bytes = '0;
            end
         end
         PH_WCRC: begin
            s.bytes++;
            if (s.bytes >= 10'd3) s.ph = PH_WRESP;
            emit(r, FILL_BYTE, 1'b1);
         end
         PH_WRESP: begin
            if (rx[4:0] != 5'h05) begin
               release_then(s, r, ST_DATA_REJ);
            end else begin
               s.ph = PH_BUSY;
               emit(r, FILL_BYTE, 1'b1);
            end
         end
         PH_BUSY: begin
            if (rx == 8'h00) emit(r, FILL_BYTE, 1'b1);
            else release_then(s, r, ST_OK);
         end
         PH_FIN: finish_req(s, r, s.pend);
         default: s.ph = PH_IDLE;
      endcase
   endfunction

   function automatic void host_step(inout host_state_t s, input logic [55:0] w,
                                     output result_type r);
      logic [1:0]  op;
      logic [31:0] sec;
      op = w[1:0];
      sec = w[33:2];
      r = '0;
      if (op == OP_BYTE) begin
         if (s.ph != PH_IDLE) on_exchange(s, r, w[41:34], w[49:42]);
      end else if (s.ph == PH_IDLE) begin
         if (op == OP_INIT) begin
            s.fast = 1'b0;
            s.kind = CARD_UNKNOWN;
            s.v2 = 1'b0;
            s.ph = PH_CLK;
            s.bytes = 10'd1;
            emit(r, FILL_BYTE, 1'b0);
         end else begin
            start_cmd(s, r, (op == OP_READ) ? CMD17 : CMD24,
                      (s.kind == CARD_HC) ? sec : (sec << 9));
         end
      end
      r.clock_fast = s.fast;
      r.card_kind = s.kind;
   endfunction

   task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] g);
      if (e !== g) begin
         err_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, e, g);
      end
   endtask

   // State after the word now on req_tdata, used by the stimulus to play the card.
   always @* begin
      pv_state = host_now;
      host_step(pv_state, req_tdata, pv_out);
   end
   assign pv_phase = pv_state.ph;
   assign pv_cmd = pv_state.cmd;
   assign pv_count = pv_state.bytes;
   assign pending = due_q.size();

   initial begin
      err_count = 0;
      checked = 0;
      host_now = reset_state();
   end

   always @(posedge clock) begin
      if (reset) begin
         host_now <= reset_state();
         due_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[26:0]);
            if (due_q.size() == 0) begin
               err_count++;
               $display("%0t: result word 0x%0h arrived with nothing expected", $time,
                        rsp_tdata);
            end else begin
               want = due_q.pop_front();
               checked++;
               check_field("tx_valid", want.tx_valid, got.tx_valid);
               check_field("tx_byte", want.tx_byte, got.tx_byte);
               check_field("select_active", want.select_active, got.select_active);
               check_field("clock_fast", want.clock_fast, got.clock_fast);
               check_field("rd_valid", want.rd_valid, got.rd_valid);
               check_field("rd_byte", want.rd_byte, got.rd_byte);
               check_field("wr_request", want.wr_request, got.wr_request);
               check_field("done_res", want.done_res, got.done_res);
               check_field("status", want.status, got.status);
               check_field("card_kind", want.card_kind, got.card_kind);
            end
         end
         host_next = host_now;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INIT_CLK:  host_next.cfg.init_clock_bytes = csr_data[7:0];
               CSR_IDLE_RTY:  host_next.cfg.go_idle_retries = csr_data;
               CSR_OPC_RTY:   host_next.cfg.op_cond_retries = csr_data;
               CSR_TOKEN_LIM: host_next.cfg.token_wait_limit = csr_data;
               CSR_POLL_LIM:  host_next.cfg.response_poll_limit = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            host_step(host_next, req_tdata, step_out);
            due_q.push_back(step_out);
         end
         host_now <= host_next;
      end
   end

endmodule

### verif/tb_sd_card_spi_host_controller.sv
`timescale 1ns / 100ps

// Testbench for the SD card SPI host controller. The top plays the part of the
// host software and of the card: it issues init, read and write requests and
// answers every exchanged byte the way a card would, mostly correctly and now
// and then not. Checking lives in sdspi_checker.
module tb_sd_card_spi_host_controller;
   import sdspi_pkg::*;

   // Cycles without any accepted word before the run is declared hung. The
   // longest quiet stretch is the deliberate result-side hold-off plus a gap.
   localparam int HANG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   int         err_count, pending, checked;
   phase_type  pv_phase;
   logic [5:0] pv_cmd;
   logic [9:0] pv_count;

   // What the controller will be doing after the last accepted word.
   phase_type  after_phase = PH_IDLE;
   logic [5:0] after_cmd = '0;
   logic [9:0] after_count = '0;

   int   useful_words = 0;
   int   n_init = 0, n_read = 0, n_write = 0;
   int   quiet_cycles = 0;
   logic force_reject = 1'b0;
   logic hold_req = 1'b0;
   logic hold_served = 1'b0;

   always #2 clock = ~clock;

   sd_card_spi_host_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sdspi_checker i_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .err_count  (err_count),
      .pending    (pending),
      .checked    (checked),
      .pv_phase   (pv_phase),
      .pv_cmd     (pv_cmd),
      .pv_count   (pv_count)
   );

   function automatic logic pct(int n);
      return $urandom_range(0, 99) < n;
   endfunction

   function automatic logic [55:0] pack_word(logic [1:0] op, logic [31:0] sec,
                                             logic [7:0] rx, logic [7:0] wb);
      return {6'd0, wb, rx, sec, op};
   endfunction

   // The R1 a card gives to each command. Mostly the answer that moves the
   // sequence forward, sometimes a refusal so that retries and errors happen.
   function automatic logic [7:0] r1_answer(logic [5:0] c);
      case (c)
         CMD0:  return pct(85) ? 8'h01 : 8'($urandom);
         CMD8:  return pct(75) ? 8'h01 : 8'h05;
         CMD55: return 8'h01;
         CMD41: return pct(60) ? 8'h00 : 8'h01;
         default: return pct(90) ? 8'h00 : {1'b0, 7'($urandom)};
      endcase
   endfunction

   // Byte the card returns in the coming exchange, given the controller phase.
   function automatic logic [7:0] card_reply(phase_type ph, logic [5:0] c, logic [9:0] n);
      if (force_reject && ph == PH_POLL) return 8'h05;
      case (ph)
         PH_POLL:  return pct(30) ? FILL_BYTE : r1_answer(c);
         // The R7 trailer: the third byte echoes the voltage range, the fourth
         // the check pattern.
         PH_TRAIL: begin
            if (n == 10'd2) return pct(90) ? 8'h01 : 8'($urandom);
            if (n == 10'd3) return pct(90) ? 8'hAA : 8'($urandom);
            return 8'h00;
         end
         PH_TOKEN: return pct(35) ? START_TOKEN : (pct(10) ? 8'($urandom) : FILL_BYTE);
         PH_WRESP: return pct(85) ? {3'($urandom), 5'h05} : 8'($urandom);
         PH_BUSY:  return pct(55) ? 8'h00 : 8'($urandom);
         default:  return 8'($urandom);
      endcase
   endfunction

   // Mostly back-to-back words, some short gaps and a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one request word and waits until it is taken. On return the
   // clock edge of the handshake is current, so the checker's preview already
   // reflects this word.
   task automatic push_word(input logic [55:0] w);
      int   gap;
      logic counts;
      counts = (w[1:0] == OP_BYTE) ? (after_phase != PH_IDLE) : (after_phase == PH_IDLE);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= w;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (counts) begin
         useful_words++;
         case (w[1:0])
            OP_INIT:  n_init++;
            OP_READ:  n_read++;
            OP_WRITE: n_write++;
            default: ;
         endcase
      end
      after_phase = pv_phase;
      after_cmd = pv_cmd;
      after_count = pv_count;
   endtask

   task automatic answer_card();
      push_word(pack_word(OP_BYTE, $urandom, card_reply(after_phase, after_cmd, after_count),
                          8'($urandom)));
   endtask

   task automatic drain_request();
      while (after_phase != PH_IDLE) answer_card();
   endtask

   // One word of the random part. When the controller is idle it gets a new
   // request; when busy it gets the card's reply, with a little noise mixed in
   // (requests while busy and exchanges while idle, both ignored).
   task automatic random_word();
      logic [1:0]  op;
      logic [31:0] sec;
      int          r;
      sec = pct(10) ? 32'd0 : (pct(10) ? 32'hFFFF_FFFF : $urandom);
      if (after_phase == PH_IDLE) begin
         r = $urandom_range(0, 99);
         if (pct(5)) op = OP_BYTE;
         else if (r < 30) op = OP_INIT;
         else if (r < 65) op = OP_READ;
         else op = OP_WRITE;
      end else begin
         op = pct(2) ? 2'($urandom_range(0, 2)) : OP_BYTE;
      end
      if (op == OP_BYTE && after_phase != PH_IDLE) answer_card();
      else push_word(pack_word(op, sec, 8'($urandom), 8'($urandom)));
   endtask

   task automatic run_random(input int quota);
      int start;
      start = useful_words;
      while (useful_words - start < quota || after_phase != PH_IDLE) random_word();
   endtask

   // Registers may only change while nothing is in flight.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_regs(input logic [15:0] clk_bytes, input logic [15:0] idle_rty,
                            input logic [15:0] opc_rty, input logic [15:0] token_lim,
                            input logic [15:0] poll_lim);
      write_reg(CSR_INIT_CLK, clk_bytes);
      write_reg(CSR_IDLE_RTY, idle_rty);
      write_reg(CSR_OPC_RTY, opc_rty);
      write_reg(CSR_TOKEN_LIM, token_lim);
      write_reg(CSR_POLL_LIM, poll_lim);
      csr_valid <= 1'b0;
   endtask

   // Result side: ready in runs of random length, plus one long hold-off while
   // the sender keeps offering, so the controller backs up and stalls its input.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         if (hold_req && !hold_served) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end else if (pct(65)) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (pct(80) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   // Hang detection: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part with reset defaults: an exchange while idle, a read
      // before init (unknown card, so the sector is shifted to a byte address
      // and wraps), a request while busy, and a write to sector zero. The card
      // refuses both commands.
      force_reject = 1'b1;
      push_word(pack_word(OP_BYTE, 32'd0, 8'hAB, 8'h00));
      push_word(pack_word(OP_READ, 32'hFFFF_FFFF, 8'h00, 8'h00));
      push_word(pack_word(OP_INIT, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
      drain_request();
      push_word(pack_word(OP_WRITE, 32'd0, 8'hFF, 8'hFF));
      drain_request();
      force_reject = 1'b0;
      settle();

      // Smallest limits: retries run out at once, a single poll, a single
      // token byte.
      load_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      run_random(260);
      settle();

      // Largest limits.
      load_regs(16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255);
      run_random(260);
      settle();

      // Moderate random limits; the long result-side hold-off happens here.
      load_regs(16'($urandom_range(1, 20)), 16'($urandom_range(1, 8)),
                16'($urandom_range(1, 8)), 16'($urandom_range(1, 30)),
                16'($urandom_range(1, 10)));
      hold_req <= 1'b1;
      run_random(270);
      settle();

      // A limit of zero behaves like one.
      load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_random(260);
      settle();

      repeat (10) @(posedge clock);
      $display("Ran %0d words: %0d init, %0d read and %0d write requests under five",
               useful_words, n_init, n_read, n_write);
      $display("register settings with random stalls; %0d result words were compared.",
               checked);
      if (err_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d results still expected", err_count, pending);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
